// ----- src/fnns_pkg.sv -----
package fnns_pkg;

   localparam int RANKS           = 5;
   localparam int INDEX_BITS      = 12;
   localparam int DIST_FIELD_BITS = 24;
   localparam int COUNT_BITS      = 3;
   localparam int NEAREST_OUT     = 4;

   localparam int MAX_POINTS_DEF  = 4096;
   localparam int DIST_BITS_DEF   = 24;

   localparam int REQ_DATA_BITS   = 40;
   localparam int RSP_DATA_BITS   = 80;

   typedef struct packed {
      logic [COUNT_BITS-1:0]      found_count;
      logic [DIST_FIELD_BITS-1:0] fifth_distance;
      logic [INDEX_BITS-1:0]      nearest_index_3;
      logic [INDEX_BITS-1:0]      nearest_index_2;
      logic [INDEX_BITS-1:0]      nearest_index_1;
      logic [INDEX_BITS-1:0]      nearest_index_0;
   } result_type;

endpackage

// ----- src/fnns_cell.sv -----
module fnns_cell #(
   parameter int DIST_BITS = fnns_pkg::DIST_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            insert_en,
   input  logic                            clear,
   input  logic [DIST_BITS-1:0]            new_dist,
   input  logic [fnns_pkg::INDEX_BITS-1:0] new_idx,
   input  logic                            left_gt,
   input  logic [DIST_BITS-1:0]            left_dist,
   input  logic [fnns_pkg::INDEX_BITS-1:0] left_idx,
   input  logic                            left_valid,
   output logic                            gt,
   output logic [DIST_BITS-1:0]            cur_dist,
   output logic [fnns_pkg::INDEX_BITS-1:0] idx,
   output logic                            valid,
   output logic [DIST_BITS-1:0]            upd_dist,
   output logic [fnns_pkg::INDEX_BITS-1:0] upd_idx,
   output logic                            upd_valid
);

   logic [DIST_BITS-1:0]            dist_ff;
   logic [fnns_pkg::INDEX_BITS-1:0] idx_ff;
   logic                            valid_ff;
   logic                            valid_in;

   // new item goes ahead of strictly larger entries and of empty slots
   assign gt = !valid_ff || (dist_ff > new_dist);

   always_comb begin
      upd_dist  = dist_ff;
      upd_idx   = idx_ff;
      upd_valid = valid_ff;
      if (insert_en) begin
         if (left_gt) begin
            upd_dist  = left_dist;
            upd_idx   = left_idx;
            upd_valid = left_valid;
         end else if (gt) begin
            upd_dist  = new_dist;
            upd_idx   = new_idx;
            upd_valid = 1'b1;
         end
      end
   end

   assign valid_in = clear ? 1'b0 : upd_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dist_ff <= upd_dist;
      idx_ff  <= upd_idx;
   end

   assign cur_dist = dist_ff;
   assign idx      = idx_ff;
   assign valid    = valid_ff;

endmodule

// ----- src/fnns_rsp_buf.sv -----
module fnns_rsp_buf (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  fnns_pkg::result_type push_data,
   output logic                 can_accept,
   output logic                 out_valid,
   output fnns_pkg::result_type out_data,
   input  logic                 out_ready
);

   logic                 out_valid_ff, out_valid_in;
   logic                 skid_valid_ff, skid_valid_in;
   fnns_pkg::result_type out_data_ff, out_data_in;
   fnns_pkg::result_type skid_data_ff, skid_data_in;
   logic                 pop;

   assign pop = out_valid_ff && out_ready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else if (push) begin
            out_data_in = push_data;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff) begin
            out_valid_in = 1'b1;
            out_data_in  = push_data;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = push_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign can_accept = !skid_valid_ff;
   assign out_valid  = out_valid_ff;
   assign out_data   = out_data_ff;

endmodule

// ----- src/five_nearest_neighbour_select_core.sv -----
// Five-cell insertion chain: one transaction per cycle while req_tready is high, each cell
// compares the new distance in parallel and shifts or loads in the same cycle.
// On the req transaction with tlast the result is registered into the rsp buffer.
// Throughput: 1 item/cycle; req_tready falls only while two results wait on rsp.
// Reset (synchronous): ranking emptied, element index back to zero, rsp empty.
module five_nearest_neighbour_select_core #(
   parameter int MAX_POINTS = fnns_pkg::MAX_POINTS_DEF,
   parameter int DIST_BITS  = fnns_pkg::DIST_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [23:0] distance, [35:24] centre_index, [39:36] zero
   input  logic [fnns_pkg::REQ_DATA_BITS-1:0] req_tdata,
   input  logic                               req_tlast,  // is_last
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [11:0] nearest_index_0, [23:12] nearest_index_1, [35:24] nearest_index_2,
   // [47:36] nearest_index_3, [71:48] fifth_distance, [74:72] found_count, [79:75] zero
   output logic [fnns_pkg::RSP_DATA_BITS-1:0] rsp_tdata
);

   localparam int IB        = fnns_pkg::INDEX_BITS;
   localparam int N         = fnns_pkg::RANKS;
   localparam int IDX_SPAN  = 2 ** IB;
   localparam int CNT_LIMIT = (MAX_POINTS > IDX_SPAN) ? IDX_SPAN : MAX_POINTS;
   localparam logic [IB-1:0] CNT_LAST = IB'(CNT_LIMIT - 1);

   logic                 accept;
   logic                 insert_en;
   logic                 clear;
   logic [DIST_BITS-1:0] new_dist;
   logic [IB-1:0]        centre;
   logic [IB-1:0]        cnt_ff, cnt_in;

   logic                 lk_gt    [0:N];
   logic [DIST_BITS-1:0] lk_dist  [0:N];
   logic [IB-1:0]        lk_idx   [0:N];
   logic                 lk_valid [0:N];

   logic [DIST_BITS-1:0] up_dist  [0:N-1];
   logic [IB-1:0]        up_idx   [0:N-1];
   logic [N-1:0]         up_valid;

   fnns_pkg::result_type res;
   fnns_pkg::result_type out_res;
   logic                 buf_ready;

   assign accept    = req_tvalid && req_tready;
   assign new_dist  = DIST_BITS'(req_tdata[fnns_pkg::DIST_FIELD_BITS-1:0]);
   assign centre    = req_tdata[fnns_pkg::DIST_FIELD_BITS +: IB];
   assign insert_en = accept && (cnt_ff != centre);
   assign clear     = accept && req_tlast;

   always_comb begin
      cnt_in = cnt_ff;
      if (accept) begin
         if (req_tlast || cnt_ff == CNT_LAST) begin
            cnt_in = '0;
         end else begin
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   assign lk_gt[0]    = 1'b0;
   assign lk_dist[0]  = '0;
   assign lk_idx[0]   = '0;
   assign lk_valid[0] = 1'b0;

   for (genvar k = 0; k < N; k++) begin : g_cell
      fnns_cell #(
         .DIST_BITS(DIST_BITS)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .insert_en (insert_en),
         .clear     (clear),
         .new_dist  (new_dist),
         .new_idx   (cnt_ff),
         .left_gt   (lk_gt[k]),
         .left_dist (lk_dist[k]),
         .left_idx  (lk_idx[k]),
         .left_valid(lk_valid[k]),
         .gt        (lk_gt[k+1]),
         .cur_dist  (lk_dist[k+1]),
         .idx       (lk_idx[k+1]),
         .valid     (lk_valid[k+1]),
         .upd_dist  (up_dist[k]),
         .upd_idx   (up_idx[k]),
         .upd_valid (up_valid[k])
      );
   end

   always_comb begin
      res.nearest_index_0 = up_valid[0] ? up_idx[0] : '0;
      res.nearest_index_1 = up_valid[1] ? up_idx[1] : '0;
      res.nearest_index_2 = up_valid[2] ? up_idx[2] : '0;
      res.nearest_index_3 = up_valid[3] ? up_idx[3] : '0;
      res.fifth_distance  = up_valid[N-1]
                            ? fnns_pkg::DIST_FIELD_BITS'(up_dist[N-1]) : '0;
      res.found_count     = fnns_pkg::COUNT_BITS'($countones(up_valid));
   end

   fnns_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (clear),
      .push_data (res),
      .can_accept(buf_ready),
      .out_valid (rsp_tvalid),
      .out_data  (out_res),
      .out_ready (rsp_tready)
   );

   assign req_tready = buf_ready;
   assign rsp_tdata  = {{(fnns_pkg::RSP_DATA_BITS - $bits(fnns_pkg::result_type)){1'b0}},
                        out_res};

endmodule

// ----- src/fnns_checker.sv -----
module fnns_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic [fnns_pkg::REQ_DATA_BITS-1:0] req_tdata,
   input logic                               req_tlast,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [fnns_pkg::RSP_DATA_BITS-1:0] rsp_tdata
);

   logic [2:0]  found;
   logic [23:0] fifth;
   logic [11:0] idx3;

   assign found = rsp_tdata[74:72];
   assign fifth = rsp_tdata[71:48];
   assign idx3  = rsp_tdata[47:36];

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp transaction dropped while stalled");

   a_idle_after_reset: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_tvalid)
      else $error("rsp valid right after reset");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> found <= 3'd5)
      else $error("found_count above five");

   a_fifth_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && found != 3'd5 |-> fifth == 24'd0)
      else $error("fifth_distance set with fewer than five found");

   a_idx3_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && found < 3'd4 |-> idx3 == 12'd0)
      else $error("nearest_index_3 set with fewer than four found");

endmodule

bind five_nearest_neighbour_select_core fnns_checker u_fnns_checker (.*);

// ----- sim/neighbour_rank_checker.sv -----
module neighbour_rank_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   input  logic                               req_tready,
   input  logic [fnns_pkg::REQ_DATA_BITS-1:0] req_tdata,
   input  logic                               req_tlast,
   input  logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic [fnns_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   output int                                 mismatch_total,
   output int                                 pending_results,
   output int                                 results_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RESULT_BITS = $bits(fnns_pkg::result_type);
   localparam int DFB         = fnns_pkg::DIST_FIELD_BITS;
   localparam int IXB         = fnns_pkg::INDEX_BITS;
   localparam int NR          = fnns_pkg::RANKS;

   logic [DFB-1:0]       rank_dist [NR];
   logic [IXB-1:0]       rank_idx  [NR];
   int                   rank_fill;
   int                   next_index;
   fnns_pkg::result_type expected_results [$];
   int                   mismatches = 0;
   int                   checked = 0;

   function automatic void clear_ranking();
      for (int k = 0; k < NR; k++) begin
         rank_dist[k] = '0;
         rank_idx[k]  = '0;
      end
      rank_fill  = 0;
      next_index = 0;
   endfunction

   // ties stay ahead: a new entry only goes in front of strictly larger distances
   function automatic void rank_element(logic [DFB-1:0] elem_dist,
                                        logic [IXB-1:0] idx);
      int pos;
      int k;
      pos = 0;
      while (pos < rank_fill && rank_dist[pos] <= elem_dist) pos++;
      if (pos < NR) begin
         k = (rank_fill < NR) ? rank_fill : NR - 1;
         while (k > pos) begin
            rank_dist[k] = rank_dist[k-1];
            rank_idx[k]  = rank_idx[k-1];
            k--;
         end
         rank_dist[pos] = elem_dist;
         rank_idx[pos]  = idx;
         if (rank_fill < NR) rank_fill++;
      end
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin : monitor
      fnns_pkg::result_type got;
      fnns_pkg::result_type want;
      logic [IXB-1:0]       centre;
      if (reset) begin
         clear_ranking();
         expected_results.delete();
      end else begin
         // the response for a list is registered, so it always comes after its last item
         if (rsp_tvalid && rsp_tready) begin
            got = fnns_pkg::result_type'(rsp_tdata[RESULT_BITS-1:0]);
            if (expected_results.size() == 0) begin
               $error("unexpected rsp transaction: %h", rsp_tdata);
               mismatches++;
            end else begin
               want = expected_results.pop_front();
               check_field("nearest_index_0", 32'(want.nearest_index_0),
                           32'(got.nearest_index_0));
               check_field("nearest_index_1", 32'(want.nearest_index_1),
                           32'(got.nearest_index_1));
               check_field("nearest_index_2", 32'(want.nearest_index_2),
                           32'(got.nearest_index_2));
               check_field("nearest_index_3", 32'(want.nearest_index_3),
                           32'(got.nearest_index_3));
               check_field("fifth_distance", 32'(want.fifth_distance),
                           32'(got.fifth_distance));
               check_field("found_count", 32'(want.found_count), 32'(got.found_count));
               check_field("rsp_tdata padding", 32'd0,
                           32'(rsp_tdata[fnns_pkg::RSP_DATA_BITS-1:RESULT_BITS]));
               checked++;
            end
         end
         if (req_tvalid && req_tready) begin
            centre = req_tdata[DFB +: IXB];
            if (IXB'(next_index) != centre)
               rank_element(req_tdata[DFB-1:0], IXB'(next_index));
            next_index = (next_index + 1 >= fnns_pkg::MAX_POINTS_DEF) ? 0 : next_index + 1;
            if (req_tlast) begin
               want.nearest_index_0 = (rank_fill > 0) ? rank_idx[0] : '0;
               want.nearest_index_1 = (rank_fill > 1) ? rank_idx[1] : '0;
               want.nearest_index_2 = (rank_fill > 2) ? rank_idx[2] : '0;
               want.nearest_index_3 = (rank_fill > 3) ? rank_idx[3] : '0;
               want.fifth_distance  = (rank_fill >= NR) ? rank_dist[NR-1] : '0;
               want.found_count     = fnns_pkg::COUNT_BITS'(rank_fill);
               expected_results = {expected_results, want};
               clear_ranking();
            end
         end
      end
      mismatch_total  <= mismatches;
      pending_results <= expected_results.size();
      results_checked <= checked;
   end

endmodule

// ----- sim/testbench.sv -----
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS = 730;
   localparam int PHASE_ITEMS  = 182;
   localparam int DFB          = fnns_pkg::DIST_FIELD_BITS;
   localparam int IXB          = fnns_pkg::INDEX_BITS;

   logic                               clock      = 1'b0;
   logic                               reset      = 1'b1;
   logic                               req_tvalid = 1'b0;
   logic                               req_tready;
   logic [fnns_pkg::REQ_DATA_BITS-1:0] req_tdata  = '0;
   logic                               req_tlast  = 1'b0;
   logic                               rsp_tvalid;
   logic                               rsp_tready = 1'b0;
   logic [fnns_pkg::RSP_DATA_BITS-1:0] rsp_tdata;

   int mismatch_total;
   int pending_results;
   int results_checked;

   int idle_pct  = 0;
   int stall_pct = 0;
   int items_sent = 0;
   int lists_sent = 0;

   int idle_by_phase  [4] = '{0, 62, 0, 36};
   int stall_by_phase [4] = '{0, 0, 62, 36};

   five_nearest_neighbour_select_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   neighbour_rank_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tlast       (req_tlast),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .mismatch_total  (mismatch_total),
      .pending_results (pending_results),
      .results_checked (results_checked)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   initial begin
      #2_000_000;
      $display("Regression FAIL");
      $finish;
   end

   // returns at the edge where the transaction is taken, tvalid still high
   task automatic send_item(input logic [DFB-1:0] dist_val,
                            input logic [IXB-1:0] centre, input logic last);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= fnns_pkg::REQ_DATA_BITS'({centre, dist_val});
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
      if (last) lists_sent++;
   endtask

   function automatic logic [DFB-1:0] pick_distance(int mode);
      case (mode)
         0: return DFB'($urandom());
         1: return DFB'($urandom_range(7));
         2: return 24'hFFFFFF - DFB'($urandom_range(7));
         default: begin
            case ($urandom_range(3))
               0: return '0;
               1: return 24'hFFFFFF;
               default: return DFB'($urandom());
            endcase
         end
      endcase
   endfunction

   initial begin : stimulus
      int             phase;
      int             random_items;
      int             len;
      int             mode;
      int             pick;
      int             centre_mode;
      logic [IXB-1:0] centre;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // nothing ranked: the only element is the centre
      send_item(24'h123456, 12'd0, 1'b1);
      // one ranked element at full-scale distance, centre never reached
      send_item(24'hFFFFFF, 12'd4095, 1'b1);
      // two ranked, equal zero distances around the centre
      send_item(24'h000000, 12'd1, 1'b0);
      send_item(24'hFFFFFF, 12'd1, 1'b0);
      send_item(24'h000000, 12'd1, 1'b1);
      // all ties: lower index wins, centre skipped in the middle
      for (int i = 0; i < 7; i++) send_item(24'd5, 12'd3, i == 6);
      // falling distances push every rank out
      for (int i = 0; i < 8; i++)
         send_item((i == 7) ? 24'h000000 : 24'hFFFFFF - 24'(i), 12'd4095, i == 7);

      phase = 0;
      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         if (phase < 3 && random_items >= (phase + 1) * PHASE_ITEMS) begin
            phase++;
            idle_pct = idle_by_phase[phase];
            stall_pct <= stall_by_phase[phase];
         end
         pick = $urandom_range(99);
         if (pick < 70) len = $urandom_range(6, 1);
         else if (pick < 92) len = $urandom_range(30, 7);
         else len = $urandom_range(80, 31);
         mode = $urandom_range(3);
         centre_mode = $urandom_range(9);
         centre = (centre_mode < 7) ? IXB'($urandom_range(len - 1))
                                    : IXB'($urandom_range(4095));
         for (int i = 0; i < len; i++) begin
            if (centre_mode == 9)
               centre = $urandom_range(1) ? IXB'(i) : IXB'($urandom_range(4095));
            send_item(pick_distance(mode), centre, i == len - 1);
            random_items++;
         end
      end
      req_tvalid <= 1'b0;
      req_tlast  <= 1'b0;

      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Streamed %0d distances in %0d lists under four stall/idle mixes,",
               items_sent, lists_sent);
      $display("with ties, skipped centres and short lists; %0d rankings compared.",
               results_checked);
      if (mismatch_total == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
